[sv/encpid_pkg.sv]
package encpid_pkg;

  // Configuration register indexes on the write port.
  typedef enum logic [2:0] {
    REG_TARGET_POSITION = 3'd0,
    REG_DRIVE_LIMIT     = 3'd1,
    REG_GAIN_P          = 3'd2,
    REG_GAIN_I          = 3'd3,
    REG_GAIN_D          = 3'd4
  } cfg_reg_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int LIMIT_W     = 15;
  localparam int GAIN_W      = 32;
  localparam int DRIVE_W     = 16;
  localparam int FRAC_W      = 16;

  // Products: 32b signed times 33b signed, and 33b signed times 33b signed.
  localparam int PROD_PI_W = 65;
  localparam int PROD_D_W  = 66;
  localparam int SUM_W     = 68;

  localparam logic signed [31:0] TARGET_RESET = 32'sd1;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET  = 15'd30000;
  localparam logic [GAIN_W-1:0]  GAIN_P_RESET = 32'd655360;
  localparam logic [GAIN_W-1:0]  GAIN_I_RESET = 32'd66;
  localparam logic [GAIN_W-1:0]  GAIN_D_RESET = 32'd66;

  // Load strobes for the two register ranks that a submodule owns.
  typedef struct packed {
    logic ld_first;
    logic ld_second;
  } stage_pair_t;

  // Saturate a 33-bit signed value to the signed 32-bit range.
  function automatic logic signed [31:0] sat33to32(input logic signed [32:0] v);
    logic signed [31:0] r;
    if (v[32] != v[31]) begin
      r = v[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

[sv/encoder_unwrap_pid_position.sv]
// Multi-turn position controller. Each input beat carries one single-turn
// encoder reading (2**COUNTS_PER_TURN_LOG2 counts per turn). The block
// extends it to a 32-bit absolute position by counting wraps (a jump of
// more than half a turn against the previous reading steps the turn count),
// then runs a PID on target_position minus position with Q16.16 gains. The
// error and the integrator saturate at the signed 32-bit limits; the PID sum
// is kept exact, truncated toward zero and clamped to +/- drive_limit. Each
// output beat carries the drive value and the absolute position of one
// reading, in order. The block takes one beat per clock while the output is
// not stalled. The seven register ranks (input, unwrap, error, integrator,
// multipliers, sum, output) lie between an accepted beat and its output; the
// input rank loads at the accepting edge. Every rank advances on its own,
// so bubbles close up and a new beat is accepted while a finished result
// waits, until all seven ranks hold a beat. Configuration registers are
// written through cfg_we/cfg_index/cfg_wdata and should only change while
// no beat is in flight; an index above four is ignored.
module encoder_unwrap_pid_position
  import encpid_pkg::*;
#(
  parameter int COUNTS_PER_TURN_LOG2 = 13
) (
  input  logic                              clk,
  input  logic                              rst_n,

  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [COUNTS_PER_TURN_LOG2-1:0]   in_raw_angle,

  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [DRIVE_W-1:0]         out_drive,
  output logic signed [31:0]                out_absolute_position,

  input  logic                              cfg_we,
  input  logic [CFG_INDEX_W-1:0]            cfg_index,
  input  logic [CFG_DATA_W-1:0]             cfg_wdata
);

  // Rank numbers along the pipeline; the last rank is the output register.
  localparam int NSTG = 7;

  logic [NSTG-1:0] v_r;
  logic [NSTG-1:0] v_nxt;
  logic [NSTG-1:0] go;
  logic [NSTG-1:0] ld;

  logic signed [31:0]   target_position_r;
  logic [LIMIT_W-1:0]   drive_limit_r;
  logic [GAIN_W-1:0]    gain_p_r;
  logic [GAIN_W-1:0]    gain_i_r;
  logic [GAIN_W-1:0]    gain_d_r;

  logic signed [31:0]      pos_b;
  logic signed [31:0]      err_d;
  logic signed [31:0]      integ_d;
  logic signed [32:0]      deriv_d;
  logic signed [31:0]      pos_d;
  logic signed [SUM_W-1:0] sum_f;
  logic signed [31:0]      pos_f;

  // A rank hands its beat on when it holds one and the next rank is either
  // empty or handing on its own beat in the same cycle.
  always_comb begin
    go[NSTG-1] = v_r[NSTG-1] && !out_stall;
    for (int k = NSTG - 2; k >= 0; k--) begin
      go[k] = v_r[k] && (!v_r[k+1] || go[k+1]);
    end
    in_stall = v_r[0] && !go[0];
    ld[0]    = in_valid && !in_stall;
    for (int k = 1; k < NSTG; k++) begin
      ld[k] = go[k-1];
    end
    v_nxt = ld | (v_r & ~go);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign out_valid = v_r[NSTG-1];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_position_r <= TARGET_RESET;
      drive_limit_r     <= LIMIT_RESET;
      gain_p_r          <= GAIN_P_RESET;
      gain_i_r          <= GAIN_I_RESET;
      gain_d_r          <= GAIN_D_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TARGET_POSITION: target_position_r <= signed'(cfg_wdata);
        REG_DRIVE_LIMIT:     drive_limit_r     <= cfg_wdata[LIMIT_W-1:0];
        REG_GAIN_P:          gain_p_r          <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_I:          gain_i_r          <= cfg_wdata[GAIN_W-1:0];
        REG_GAIN_D:          gain_d_r          <= cfg_wdata[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Ranks 0 and 1: input register and wrap counting.
  encpid_unwrap #(
    .COUNTS_PER_TURN_LOG2(COUNTS_PER_TURN_LOG2)
  ) u_unwrap (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       ({ld[0], ld[1]}),
    .raw_angle (in_raw_angle),
    .pos_r     (pos_b)
  );

  // Ranks 2 and 3: saturated error, then integrator and derivative.
  encpid_err_integ u_err_integ (
    .clk             (clk),
    .rst_n           (rst_n),
    .ctl             ({ld[2], ld[3]}),
    .target_position (target_position_r),
    .pos             (pos_b),
    .err_r           (err_d),
    .integ_r         (integ_d),
    .deriv_r         (deriv_d),
    .pos_r           (pos_d)
  );

  // Ranks 4 and 5: the three gain products, then their exact sum.
  encpid_mac u_mac (
    .clk    (clk),
    .ctl    ({ld[4], ld[5]}),
    .gain_p (gain_p_r),
    .gain_i (gain_i_r),
    .gain_d (gain_d_r),
    .err    (err_d),
    .integ  (integ_d),
    .deriv  (deriv_d),
    .pos    (pos_d),
    .sum_r  (sum_f),
    .pos_r  (pos_f)
  );

  // Rank 6: drop the fraction, clamp, and hold the result for the output.
  encpid_clamp u_clamp (
    .clk         (clk),
    .ld          (ld[NSTG-1]),
    .drive_limit (drive_limit_r),
    .sum         (sum_f),
    .pos         (pos_f),
    .drive_r     (out_drive),
    .pos_r       (out_absolute_position)
  );

endmodule

[sv/encpid_unwrap.sv]
module encpid_unwrap
  import encpid_pkg::*;
#(
  parameter int COUNTS_PER_TURN_LOG2 = 13
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  stage_pair_t                            ctl,
  input  logic [COUNTS_PER_TURN_LOG2-1:0]        raw_angle,
  output logic signed [31:0]                     pos_r
);

  localparam int LOG2 = COUNTS_PER_TURN_LOG2;
  localparam int TW   = 32 - LOG2;
  localparam logic signed [LOG2:0] HALF_S     = (LOG2+1)'(1 << (LOG2 - 1));
  localparam logic signed [LOG2:0] NEG_HALF_S = -HALF_S;

  logic [LOG2-1:0]   raw_r;
  logic [LOG2-1:0]   prev_angle_r;
  logic [TW-1:0]     turn_r;
  logic [TW-1:0]     turn_nxt;
  logic signed [LOG2:0] diff;

  // A jump of more than half a turn is taken as a wrap through zero.
  always_comb begin
    diff = signed'({1'b0, raw_r}) - signed'({1'b0, prev_angle_r});
    if (diff > HALF_S) begin
      turn_nxt = turn_r - TW'(1);
    end else if (diff < NEG_HALF_S) begin
      turn_nxt = turn_r + TW'(1);
    end else begin
      turn_nxt = turn_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      turn_r       <= '0;
      prev_angle_r <= '0;
    end else if (ctl.ld_second) begin
      turn_r       <= turn_nxt;
      prev_angle_r <= raw_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_first) begin
      raw_r <= raw_angle;
    end
    if (ctl.ld_second) begin
      pos_r <= signed'({turn_nxt, raw_r});
    end
  end

endmodule

[sv/encpid_err_integ.sv]
module encpid_err_integ
  import encpid_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  stage_pair_t        ctl,
  input  logic signed [31:0] target_position,
  input  logic signed [31:0] pos,
  output logic signed [31:0] err_r,
  output logic signed [31:0] integ_r,
  output logic signed [32:0] deriv_r,
  output logic signed [31:0] pos_r
);

  logic signed [31:0] err_c_r;
  logic signed [31:0] pos_c_r;
  logic signed [31:0] integral_r;
  logic signed [31:0] prev_err_r;
  logic signed [31:0] err_nxt;
  logic signed [31:0] integral_nxt;

  assign err_nxt      = sat33to32(33'(target_position) - 33'(pos));
  assign integral_nxt = sat33to32(33'(integral_r) + 33'(err_c_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
      prev_err_r <= '0;
    end else if (ctl.ld_second) begin
      integral_r <= integral_nxt;
      prev_err_r <= err_c_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_first) begin
      err_c_r <= err_nxt;
      pos_c_r <= pos;
    end
    if (ctl.ld_second) begin
      err_r   <= err_c_r;
      integ_r <= integral_nxt;
      deriv_r <= 33'(err_c_r) - 33'(prev_err_r);
      pos_r   <= pos_c_r;
    end
  end

endmodule

[sv/encpid_mac.sv]
module encpid_mac
  import encpid_pkg::*;
(
  input  logic                    clk,
  input  stage_pair_t             ctl,
  input  logic [GAIN_W-1:0]       gain_p,
  input  logic [GAIN_W-1:0]       gain_i,
  input  logic [GAIN_W-1:0]       gain_d,
  input  logic signed [31:0]      err,
  input  logic signed [31:0]      integ,
  input  logic signed [32:0]      deriv,
  input  logic signed [31:0]      pos,
  output logic signed [SUM_W-1:0] sum_r,
  output logic signed [31:0]      pos_r
);

  logic signed [PROD_PI_W-1:0] prod_p_r;
  logic signed [PROD_PI_W-1:0] prod_i_r;
  logic signed [PROD_D_W-1:0]  prod_d_r;
  logic signed [31:0]          pos_e_r;

  // Gains are unsigned Q16.16, so each is widened by a zero bit first.
  always_ff @(posedge clk) begin
    if (ctl.ld_first) begin
      prod_p_r <= err * signed'({1'b0, gain_p});
      prod_i_r <= integ * signed'({1'b0, gain_i});
      prod_d_r <= deriv * signed'({1'b0, gain_d});
      pos_e_r  <= pos;
    end
    if (ctl.ld_second) begin
      sum_r <= SUM_W'(prod_p_r) + SUM_W'(prod_i_r) + SUM_W'(prod_d_r);
      pos_r <= pos_e_r;
    end
  end

endmodule

[sv/encpid_clamp.sv]
module encpid_clamp
  import encpid_pkg::*;
(
  input  logic                      clk,
  input  logic                      ld,
  input  logic [LIMIT_W-1:0]        drive_limit,
  input  logic signed [SUM_W-1:0]   sum,
  input  logic signed [31:0]        pos,
  output logic signed [DRIVE_W-1:0] drive_r,
  output logic signed [31:0]        pos_r
);

  localparam int Q_W = SUM_W - FRAC_W;

  logic                 neg;
  logic [SUM_W-1:0]     mag;
  logic [Q_W-1:0]       quot;
  logic [LIMIT_W-1:0]   clipped;
  logic [DRIVE_W-1:0]   drive_nxt;

  // Work on the magnitude so that dropping the fraction truncates toward zero.
  always_comb begin
    neg  = sum[SUM_W-1];
    mag  = neg ? SUM_W'(-sum) : SUM_W'(sum);
    quot = mag[SUM_W-1:FRAC_W];
    if (quot > Q_W'(drive_limit)) begin
      clipped = drive_limit;
    end else begin
      clipped = quot[LIMIT_W-1:0];
    end
    drive_nxt = neg ? -{1'b0, clipped} : {1'b0, clipped};
  end

  always_ff @(posedge clk) begin
    if (ld) begin
      drive_r <= signed'(drive_nxt);
      pos_r   <= pos;
    end
  end

endmodule

[sv/encpid_chk.sv]
module encpid_chk
  import encpid_pkg::*;
(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      in_stall,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic signed [DRIVE_W-1:0] out_drive,
  input logic signed [31:0]        out_absolute_position
);

  // A result held under stall keeps its payload.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_drive)
      && $stable(out_absolute_position))
    else $error("output beat changed while stalled");

  // The input only stalls when a finished result is backed up at the output.
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("input stalled with an empty output register");

  // The clamp never yields the most negative code.
  a_drive_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_drive != 16'sh8000)
    else $error("drive outside the symmetric range");

  // Reset empties the pipeline.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid && !in_stall)
    else $error("pipeline not empty after reset");

endmodule

bind encoder_unwrap_pid_position encpid_chk u_encpid_chk (
  .clk                   (clk),
  .rst_n                 (rst_n),
  .in_stall              (in_stall),
  .out_valid             (out_valid),
  .out_stall             (out_stall),
  .out_drive             (out_drive),
  .out_absolute_position (out_absolute_position)
);
